### sv/csf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csf_pkg
// Shared constants for the changed span finder: register indexes, reset
// values, field widths and default sizes.
// ----------------------------------------------------------------------------
package csf_pkg;

	// field widths
	localparam int CHAR_W     = 8;
	localparam int COLOR_W    = 16;
	localparam int ROW_OUT_W  = 8;
	localparam int LEFT_OUT_W = 8;
	localparam int RIGHT_OUT_W = 9;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 9;
	localparam int SIZE_CFG_W = 9;
	localparam int GAP_W      = 8;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_LINE_WIDTH    = cfg_idx_t'(0);
	localparam cfg_idx_t REG_LINE_COUNT    = cfg_idx_t'(1);
	localparam cfg_idx_t REG_GAP_THRESHOLD = cfg_idx_t'(2);
	localparam cfg_idx_t REG_COLOR_COMPARE = cfg_idx_t'(3);

	// register reset values
	localparam logic [SIZE_CFG_W-1:0] LINE_WIDTH_RST    = SIZE_CFG_W'(80);
	localparam logic [SIZE_CFG_W-1:0] LINE_COUNT_RST    = SIZE_CFG_W'(25);
	localparam logic [GAP_W-1:0]      GAP_THRESHOLD_RST = '0;
	localparam logic                  COLOR_COMPARE_RST = 1'b1;

	// default sizes
	localparam int MAX_COLUMNS_DEF = 256;
	localparam int MAX_ROWS_DEF    = 256;
	localparam int COLOR_BITS_DEF  = 16;

endpackage

### sv/changed_span_finder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// changed_span_finder_core
// Compares two frames cell by cell in raster order and reports each span
// of changed cells in a row as row, first column and end column.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid, in_stall, char_*, color_*       | in
//  out     | out_valid, out_stall, span_row/left/right | out
//  cfg     | cfg_we, cfg_index, cfg_data               | in
//
//  One cell per clock while the result side is not stalled; a cell waits in the
//  input register and its span, if any, is loaded into the result register as it leaves.
//  The input register frees whenever the result register is empty or taken.
//  Reset clears positions, the open span and the registers to their defaults.
//  A stalled result holds the cell behind it; a third cell waits upstream.
//
module changed_span_finder_core #(
	parameter int MAX_COLUMNS = csf_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = csf_pkg::MAX_ROWS_DEF,
	parameter int COLOR_BITS  = csf_pkg::COLOR_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  csf_pkg::cfg_idx_t                  cfg_index,
	input  logic [csf_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [csf_pkg::CHAR_W-1:0]         char_new,
	input  logic [csf_pkg::CHAR_W-1:0]         char_old,
	input  logic [csf_pkg::COLOR_W-1:0]        color_new,
	input  logic [csf_pkg::COLOR_W-1:0]        color_old,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [csf_pkg::ROW_OUT_W-1:0]      span_row,
	output logic [csf_pkg::LEFT_OUT_W-1:0]     span_left,
	output logic [csf_pkg::RIGHT_OUT_W-1:0]    span_right
);

	localparam int COL_W = $clog2(MAX_COLUMNS);
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int W_W   = (csf_pkg::SIZE_CFG_W > COL_W + 1) ? csf_pkg::SIZE_CFG_W : COL_W + 1;
	localparam int H_W   = (csf_pkg::SIZE_CFG_W > ROW_W + 1) ? csf_pkg::SIZE_CFG_W : ROW_W + 1;
	localparam int CMP_W = (COLOR_BITS < csf_pkg::COLOR_W) ? COLOR_BITS : csf_pkg::COLOR_W;
	localparam logic [W_W-1:0] MAX_W = W_W'(MAX_COLUMNS);
	localparam logic [H_W-1:0] MAX_H = H_W'(MAX_ROWS);

	// configuration registers
	logic [csf_pkg::SIZE_CFG_W-1:0] line_width_q;
	logic [csf_pkg::SIZE_CFG_W-1:0] line_count_q;
	logic [csf_pkg::GAP_W-1:0]      gap_threshold_q;
	logic                           color_compare_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q    <= csf_pkg::LINE_WIDTH_RST;
			line_count_q    <= csf_pkg::LINE_COUNT_RST;
			gap_threshold_q <= csf_pkg::GAP_THRESHOLD_RST;
			color_compare_q <= csf_pkg::COLOR_COMPARE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				csf_pkg::REG_LINE_WIDTH:    line_width_q    <= cfg_data;
				csf_pkg::REG_LINE_COUNT:    line_count_q    <= cfg_data;
				csf_pkg::REG_GAP_THRESHOLD: gap_threshold_q <= cfg_data[csf_pkg::GAP_W-1:0];
				csf_pkg::REG_COLOR_COMPARE: color_compare_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	logic                        s1_valid_q;
	logic [csf_pkg::CHAR_W-1:0]  char_new_s1, char_old_s1;
	logic [CMP_W-1:0]            color_new_s1, color_old_s1;
	logic                        s1_adv;
	logic                        in_take;

	assign s1_adv   = s1_valid_q && (!out_valid || !out_stall);
	assign in_stall = s1_valid_q && !s1_adv;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_take) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			char_new_s1  <= char_new;
			char_old_s1  <= char_old;
			color_new_s1 <= color_new[CMP_W-1:0];
			color_old_s1 <= color_old[CMP_W-1:0];
		end
	end

	// scan state
	logic [COL_W-1:0]         col_q;
	logic [ROW_W-1:0]         row_q;
	logic                     span_open_q;
	logic [COL_W-1:0]         span_start_q;
	logic [COL_W:0]           span_end_q;
	logic [csf_pkg::GAP_W-1:0] gap_left_q;

	logic [W_W-1:0]           eff_w;
	logic [H_W-1:0]           eff_h;
	logic                     changed;
	logic                     gap_close;
	logic                     open_mid;
	logic                     row_end;
	logic                     frame_end;
	logic                     emit;
	logic [COL_W-1:0]         start_nx;
	logic [COL_W:0]           end_nx;
	logic [csf_pkg::GAP_W-1:0] gap_nx;
	logic [COL_W:0]           col_inc;
	logic [ROW_W:0]           row_inc;

	always_comb begin
		eff_w = (line_width_q == '0 || W_W'(line_width_q) > MAX_W) ? MAX_W : W_W'(line_width_q);
		eff_h = (line_count_q == '0 || H_W'(line_count_q) > MAX_H) ? MAX_H : H_W'(line_count_q);

		changed = (char_new_s1 != char_old_s1) ||
			(color_compare_q && (color_new_s1 != color_old_s1));

		gap_close = !changed && span_open_q && (gap_left_q == '0);
		open_mid  = changed || (span_open_q && !gap_close);

		start_nx = (changed && !span_open_q) ? col_q : span_start_q;
		col_inc  = {1'b0, col_q} + 1'b1;
		end_nx   = changed ? col_inc : span_end_q;

		if (changed) begin
			gap_nx = gap_threshold_q;
		end else if (span_open_q && gap_left_q != '0) begin
			gap_nx = gap_left_q - 1'b1;
		end else begin
			gap_nx = gap_left_q;
		end

		row_inc   = {1'b0, row_q} + 1'b1;
		row_end   = W_W'(col_inc) >= eff_w;
		frame_end = H_W'(row_inc) >= eff_h;
		emit      = gap_close || (row_end && open_mid);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			span_open_q  <= 1'b0;
			span_start_q <= '0;
			span_end_q   <= '0;
			gap_left_q   <= '0;
		end else if (s1_adv) begin
			span_open_q  <= open_mid && !row_end;
			span_start_q <= start_nx;
			span_end_q   <= end_nx;
			gap_left_q   <= gap_nx;
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
		end
	end

	// result register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit) begin
			span_row   <= csf_pkg::ROW_OUT_W'(row_q);
			span_left  <= csf_pkg::LEFT_OUT_W'(start_nx);
			span_right <= csf_pkg::RIGHT_OUT_W'(end_nx);
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	// an open span always covers at least its first changed cell
	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		span_open_q |-> ({1'b0, span_start_q} < span_end_q))
		else $error("open span has end at or before start");

	// the input side only waits on a held cell
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_q && out_valid_q && out_stall))
		else $error("input stalled without a blocked cell");

	// a new result comes from a cell that sat in the input register
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_valid_q))
		else $error("result appeared with no cell behind it");
`endif

endmodule

### bench/span_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// span_checker
// Watches the cell, span and register ports of the changed span finder,
// keeps its own copy of the scan position, open span and registers, works
// out the span each accepted cell closes, and compares every delivered span
// field by field against the oldest one still owed.
// ----------------------------------------------------------------------------
module span_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  csf_pkg::cfg_idx_t                   cfg_index,
	input  logic [csf_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [csf_pkg::CHAR_W-1:0]          char_new,
	input  logic [csf_pkg::CHAR_W-1:0]          char_old,
	input  logic [csf_pkg::COLOR_W-1:0]         color_new,
	input  logic [csf_pkg::COLOR_W-1:0]         color_old,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [csf_pkg::ROW_OUT_W-1:0]       span_row,
	input  logic [csf_pkg::LEFT_OUT_W-1:0]      span_left,
	input  logic [csf_pkg::RIGHT_OUT_W-1:0]     span_right,
	output int                                  pending,
	output int                                  mismatch_count,
	output int                                  spans_checked
);

	localparam logic [csf_pkg::COLOR_W-1:0] COLOR_MASK =
		{csf_pkg::COLOR_W{1'b1}} >> (csf_pkg::COLOR_W - csf_pkg::COLOR_BITS_DEF);

	typedef struct packed {
		logic [csf_pkg::ROW_OUT_W-1:0]   row;
		logic [csf_pkg::LEFT_OUT_W-1:0]  left;
		logic [csf_pkg::RIGHT_OUT_W-1:0] right;
	} span_t;

	span_t owed_spans[$];
	span_t got, want;

	logic [csf_pkg::SIZE_CFG_W-1:0] width_reg, count_reg;
	logic [csf_pkg::GAP_W-1:0]      gap_reg;
	logic                           color_reg;

	int col_pos, row_pos, span_first, span_stop, gap_budget;
	bit span_active;
	int errors, checked;

	task automatic close_span();
		span_t s;
		s.row   = csf_pkg::ROW_OUT_W'(row_pos);
		s.left  = csf_pkg::LEFT_OUT_W'(span_first);
		s.right = csf_pkg::RIGHT_OUT_W'(span_stop);
		owed_spans.insert(owed_spans.size(), s);
		span_active = 1'b0;
	endtask

	task automatic scan_cell(input logic [csf_pkg::CHAR_W-1:0] cn, co,
		input logic [csf_pkg::COLOR_W-1:0] kn, ko);
		int w, h;
		bit differs;
		w = (width_reg == 0 || width_reg > csf_pkg::MAX_COLUMNS_DEF) ?
			csf_pkg::MAX_COLUMNS_DEF : int'(width_reg);
		h = (count_reg == 0 || count_reg > csf_pkg::MAX_ROWS_DEF) ?
			csf_pkg::MAX_ROWS_DEF : int'(count_reg);
		differs = (cn != co) || (color_reg && ((kn ^ ko) & COLOR_MASK) != '0);
		if (differs) begin
			if (!span_active) begin
				span_active = 1'b1;
				span_first = col_pos;
			end
			gap_budget = int'(gap_reg);
			span_stop = col_pos + 1;
		end else if (span_active) begin
			if (gap_budget == 0)
				close_span();
			else
				gap_budget--;
		end
		// a row ends at the width or past it, if the width shrank mid-row
		if (col_pos + 1 >= w) begin
			if (span_active)
				close_span();
			col_pos = 0;
			row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = csf_pkg::LINE_WIDTH_RST;
			count_reg = csf_pkg::LINE_COUNT_RST;
			gap_reg = csf_pkg::GAP_THRESHOLD_RST;
			color_reg = csf_pkg::COLOR_COMPARE_RST;
			col_pos = 0;
			row_pos = 0;
			span_first = 0;
			span_stop = 0;
			gap_budget = 0;
			span_active = 1'b0;
			errors = 0;
			checked = 0;
			owed_spans.delete();
			pending <= 0;
			mismatch_count <= 0;
			spans_checked <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					csf_pkg::REG_LINE_WIDTH:
						width_reg = cfg_data[csf_pkg::SIZE_CFG_W-1:0];
					csf_pkg::REG_LINE_COUNT:
						count_reg = cfg_data[csf_pkg::SIZE_CFG_W-1:0];
					csf_pkg::REG_GAP_THRESHOLD:
						gap_reg = cfg_data[csf_pkg::GAP_W-1:0];
					csf_pkg::REG_COLOR_COMPARE:
						color_reg = cfg_data[0];
					default: ;
				endcase
			end
			// the delivered span always stems from an older cell, so compare first
			if (out_valid && !out_stall) begin
				got.row = span_row;
				got.left = span_left;
				got.right = span_right;
				checked++;
				if (owed_spans.size() == 0) begin
					$display("%0t unexpected span: expected none, actual row %0d left %0d right %0d",
						$time, got.row, got.left, got.right);
					errors++;
				end else begin
					want = owed_spans.pop_front();
					if (got.row != want.row) begin
						$display("%0t span_row: expected %0d actual %0d", $time, want.row, got.row);
						errors++;
					end
					if (got.left != want.left) begin
						$display("%0t span_left: expected %0d actual %0d", $time, want.left, got.left);
						errors++;
					end
					if (got.right != want.right) begin
						$display("%0t span_right: expected %0d actual %0d",
							$time, want.right, got.right);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall)
				scan_cell(char_new, char_old, color_new, color_old);
			pending <= owed_spans.size();
			mismatch_count <= errors;
			spans_checked <= checked;
		end
	end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams cell pairs into the changed span finder under a series of frame
// sizes, gap thresholds and color modes, with random sender gaps and
// receiver stalls; span_checker predicts and checks every span.
// ----------------------------------------------------------------------------
module testbench;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                cfg_we;
	csf_pkg::cfg_idx_t                   cfg_index;
	logic [csf_pkg::CFG_DATA_W-1:0]      cfg_data;
	logic                                in_valid;
	logic                                in_stall;
	logic [csf_pkg::CHAR_W-1:0]          char_new, char_old;
	logic [csf_pkg::COLOR_W-1:0]         color_new, color_old;
	logic                                out_valid;
	logic                                out_stall;
	logic [csf_pkg::ROW_OUT_W-1:0]       span_row;
	logic [csf_pkg::LEFT_OUT_W-1:0]      span_left;
	logic [csf_pkg::RIGHT_OUT_W-1:0]     span_right;

	int pending, mismatch_count, spans_checked;
	int gap_pct = 0;
	int stall_pct = 0;
	int cells_sent = 0;
	int settings_used = 0;

	changed_span_finder_core u_top (.*);
	span_checker u_checker (.*);

	always #1 clk = ~clk;

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	initial begin
		#400000;
		$display("timeout: spans still outstanding");
		$display("end of test: mismatches");
		$finish;
	end

	task automatic write_reg(input csf_pkg::cfg_idx_t idx,
		input logic [csf_pkg::CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic load_settings(input int w, h, gap, cmp);
		write_reg(csf_pkg::REG_LINE_WIDTH, csf_pkg::CFG_DATA_W'(w));
		write_reg(csf_pkg::REG_LINE_COUNT, csf_pkg::CFG_DATA_W'(h));
		write_reg(csf_pkg::REG_GAP_THRESHOLD, {1'($urandom), csf_pkg::GAP_W'(gap)});
		write_reg(csf_pkg::REG_COLOR_COMPARE, {8'($urandom), 1'(cmp)});
		// unmapped index: must leave every register alone
		write_reg(csf_pkg::cfg_idx_t'($urandom_range(4, 15)),
			csf_pkg::CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic send_cell(input logic [csf_pkg::CHAR_W-1:0] cn, co,
		input logic [csf_pkg::COLOR_W-1:0] kn, ko);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		char_new <= cn;
		char_old <= co;
		color_new <= kn;
		color_old <= ko;
		do
			@(posedge clk);
		while (in_stall);
		cells_sent++;
	endtask

	task automatic send_random(input int density);
		logic [csf_pkg::CHAR_W-1:0]  cn, co;
		logic [csf_pkg::COLOR_W-1:0] kn, ko;
		cn = csf_pkg::CHAR_W'($urandom);
		co = cn;
		kn = csf_pkg::COLOR_W'($urandom);
		ko = kn;
		if ($urandom_range(99) < density) begin
			if ($urandom_range(1))
				co = cn ^ csf_pkg::CHAR_W'($urandom_range(1, 255));
			else
				ko = kn ^ csf_pkg::COLOR_W'($urandom_range(1, 65535));
		end else if ($urandom_range(3) == 0) begin
			// color noise: a change only while colors are compared
			ko = csf_pkg::COLOR_W'($urandom);
		end
		send_cell(cn, co, kn, ko);
	endtask

	// hold off until every owed span is out and the pipe has settled
	task automatic drain_block();
		in_valid <= 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		repeat (2) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input int w, h, gap, cmp, cells, density,
		input idle_mode_t mode);
		load_settings(w, h, gap, cmp);
		case (mode)
			IDLE_SENDER: gap_pct = 58;
			IDLE_RECEIVER: stall_pct = 58;
			IDLE_BOTH: begin
				gap_pct = 34;
				stall_pct = 34;
			end
			default: ;
		endcase
		repeat (cells)
			send_random(density);
		drain_block();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= csf_pkg::REG_LINE_WIDTH;
		cfg_data <= '0;
		in_valid <= 1'b0;
		char_new <= '0;
		char_old <= '0;
		color_new <= '0;
		color_old <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 8 x 2 frame, two tolerated gap cells, colors compared
		load_settings(8, 2, 2, 1);
		send_cell(8'h00, 8'h00, 16'h0000, 16'h0000);
		send_cell(8'hFF, 8'h00, 16'h0000, 16'h0000);
		send_cell(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
		send_cell(8'h41, 8'h41, 16'hFFFF, 16'h0000);
		send_cell(8'h20, 8'h20, 16'h1234, 16'h1234);
		send_cell(8'h20, 8'h20, 16'h0000, 16'h0000);
		send_cell(8'h20, 8'h20, 16'hFFFF, 16'hFFFF);
		send_cell(8'h00, 8'hFF, 16'hFFFF, 16'hFFFF);
		// second row: gap bridged exactly, then closed by the gap
		send_cell(8'h80, 8'h7F, 16'h8000, 16'h8000);
		send_cell(8'h55, 8'h55, 16'h0001, 16'h0001);
		send_cell(8'hAA, 8'hAA, 16'h0100, 16'h0100);
		send_cell(8'h01, 8'h02, 16'h0000, 16'h0000);
		send_cell(8'h10, 8'h10, 16'h00FF, 16'h00FF);
		send_cell(8'h10, 8'h10, 16'hFF00, 16'hFF00);
		send_cell(8'h10, 8'h10, 16'h7FFF, 16'h7FFF);
		send_cell(8'h10, 8'h10, 16'h0F0F, 16'h0F0F);
		// frame wraps: whole row changed, closed at the row end
		send_cell(8'hAA, 8'h55, 16'h0000, 16'h0000);
		send_cell(8'h33, 8'h33, 16'hAAAA, 16'h5555);
		send_cell(8'h55, 8'hAA, 16'hFFFF, 16'hFFFF);
		send_cell(8'hCC, 8'hCC, 16'h5555, 16'hAAAA);
		send_cell(8'h00, 8'h80, 16'h0000, 16'h0000);
		send_cell(8'h7E, 8'h7E, 16'h0000, 16'h8001);
		send_cell(8'hFE, 8'h01, 16'hFFFF, 16'h0000);
		send_cell(8'h99, 8'h99, 16'hF0F0, 16'h0F0F);
		drain_block();

		// width, count, gap, color, cells, change percent, idling mode
		run_phase(16, 4, 0, 1, 250, 30, IDLE_NONE);
		run_phase(5, 3, 3, 0, 250, 40, IDLE_SENDER);
		run_phase(1, 1, 0, 1, 150, 50, IDLE_RECEIVER);
		run_phase(256, 256, 255, 1, 300, 5, IDLE_BOTH);
		run_phase(3, 0, 1, 0, 200, 50, IDLE_NONE);
		run_phase(257, 2, 4, 1, 120, 20, IDLE_SENDER);
		run_phase(7, 511, 2, 1, 200, 35, IDLE_RECEIVER);
		run_phase(2, 5, 255, 0, 200, 60, IDLE_BOTH);
		run_phase(12, 3, 0, 1, 200, 15, IDLE_NONE);
		run_phase(511, 1, 0, 1, 100, 50, IDLE_SENDER);
		run_phase(9, 256, 1, 1, 200, 45, IDLE_BOTH);

		$display("streamed %0d cells under %0d register settings, %0d spans compared",
			cells_sent, settings_used, spans_checked);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
